>>> rtl/bfnr_pkg.sv
// ----------------------------------------------------------------------------
// bfnr_pkg
// Shared types, constants and helper functions of the burst framer with
// preamble and tail insertion and NRZ mapping.
// ----------------------------------------------------------------------------
package bfnr_pkg;

    localparam int MAX_PREAMBLE = 8;
    localparam int MAX_TAIL     = 8;
    localparam int MAX_INTERP   = 3;
    localparam int MAX_ZERO_PAD = 4;

    localparam int BYTE_W    = 8;
    localparam int SAMPLE_W  = 9;
    localparam int INTERP_W  = 2;
    localparam int PAD_W     = 3;
    localparam int LEN_W     = 4;
    localparam int SYMS_W    = 64;
    localparam int CNT_W     = 2;
    localparam int SYM_IDX_W = 3;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NRZ_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_FACTOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_PAD_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_SYMBOLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_LENGTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_SYMBOLS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL_LENGTH      = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE_ZERO,
        PH_PREAMBLE,
        PH_DATA,
        PH_TAIL,
        PH_POST_ZERO
    } phase_t;

    // Effective (saturated) configuration as seen by the sequencer.
    typedef struct packed {
        logic                nrz;
        logic [INTERP_W-1:0] interp;
        logic [PAD_W-1:0]    pad;
        logic [SYMS_W-1:0]   pre_syms;
        logic [LEN_W-1:0]    pre_len;
        logic [SYMS_W-1:0]   tail_syms;
        logic [LEN_W-1:0]    tail_len;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_of_item;
        logic                       last_of_burst;
    } samp_t;

    // Order of sections within one input item; empty sections are skipped.
    function automatic phase_t phase_after(
        input phase_t cur,
        input logic   first,
        input logic   last,
        input logic   pad_nz,
        input logic   pre_nz,
        input logic   tail_nz
    );
        phase_t nxt;
        nxt = PH_IDLE;
        case (cur)
            PH_IDLE:
            begin
                if (first && pad_nz)
                    nxt = PH_PRE_ZERO;
                else if (first && pre_nz)
                    nxt = PH_PREAMBLE;
                else
                    nxt = PH_DATA;
            end
            PH_PRE_ZERO:  nxt = pre_nz ? PH_PREAMBLE : PH_DATA;
            PH_PREAMBLE:  nxt = PH_DATA;
            PH_DATA:
            begin
                if (last && tail_nz)
                    nxt = PH_TAIL;
                else if (last && pad_nz)
                    nxt = PH_POST_ZERO;
                else
                    nxt = PH_IDLE;
            end
            PH_TAIL:      nxt = pad_nz ? PH_POST_ZERO : PH_IDLE;
            PH_POST_ZERO: nxt = PH_IDLE;
            default:      nxt = PH_IDLE;
        endcase
        return nxt;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] map_symbol(
        input logic              nrz,
        input logic [BYTE_W-1:0] b
    );
        logic signed [SAMPLE_W-1:0] s;
        if (nrz)
            s = (b != '0) ? SAMPLE_W'(1) : SAMPLE_W'(-1);
        else
            s = {1'b0, b};
        return s;
    endfunction

endpackage

>>> rtl/burst_framer_nrz_repeat_top.sv
// ----------------------------------------------------------------------------
// burst_framer_nrz_repeat_top
// Burst framer: zero padding, preamble and tail insertion, symbol repetition
// and optional NRZ mapping of a byte stream into signed samples.
// ----------------------------------------------------------------------------
// The sequencer phase register and the output register lie between accepting
// an item and its first sample. Throughput: one sample per cycle from the
// shared sequencer unless out_stall holds it; the input stays stalled until
// the last of an item's samples is taken (interp_factor mid-burst, up to 59).
// Reset: asynchronous, active low; configuration returns to NRZ mode, repeat
// factor one, no padding, empty preamble and tail, and no burst in progress.
module burst_framer_nrz_repeat_top
    import bfnr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [SYMS_W-1:0]          cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [BYTE_W-1:0]          data_byte,
    input  logic                       last_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                       last_of_item,
    output logic                       last_of_burst
);

    cfg_t  cfg;
    samp_t emit;
    samp_t out_data;
    logic  emit_valid;
    logic  emit_take;
    logic  busy;
    logic  in_fire;

    assign cfg_ready = 1'b1;
    assign in_stall  = busy;
    assign in_fire   = in_valid && !busy;

    bfnr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bfnr_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_fire    (in_fire),
        .in_byte    (data_byte),
        .in_last    (last_byte),
        .busy       (busy),
        .emit_valid (emit_valid),
        .emit       (emit),
        .emit_take  (emit_take)
    );

    bfnr_outreg u_outreg (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit_valid (emit_valid),
        .emit       (emit),
        .emit_take  (emit_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    assign sample        = out_data.sample;
    assign last_of_item  = out_data.last_of_item;
    assign last_of_burst = out_data.last_of_burst;

endmodule

>>> rtl/bfnr_cfg.sv
// ----------------------------------------------------------------------------
// bfnr_cfg
// Configuration register file with saturation of the sizes to the limits.
// ----------------------------------------------------------------------------
module bfnr_cfg
    import bfnr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [SYMS_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    logic                nrz_reg;
    logic [INTERP_W-1:0] interp_reg;
    logic [PAD_W-1:0]    pad_reg;
    logic [SYMS_W-1:0]   pre_syms_reg;
    logic [LEN_W-1:0]    pre_len_reg;
    logic [SYMS_W-1:0]   tail_syms_reg;
    logic [LEN_W-1:0]    tail_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrz_reg       <= 1'b1;
            interp_reg    <= INTERP_W'(1);
            pad_reg       <= '0;
            pre_syms_reg  <= '0;
            pre_len_reg   <= '0;
            tail_syms_reg <= '0;
            tail_len_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_NRZ_MODE:         nrz_reg       <= wr_data[0];
                REG_INTERP_FACTOR:    interp_reg    <= wr_data[INTERP_W-1:0];
                REG_ZERO_PAD_COUNT:   pad_reg       <= wr_data[PAD_W-1:0];
                REG_PREAMBLE_SYMBOLS: pre_syms_reg  <= wr_data;
                REG_PREAMBLE_LENGTH:  pre_len_reg   <= wr_data[LEN_W-1:0];
                REG_TAIL_SYMBOLS:     tail_syms_reg <= wr_data;
                REG_TAIL_LENGTH:      tail_len_reg  <= wr_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.nrz = nrz_reg;
        // A repeat factor of zero behaves as one.
        if (interp_reg == '0)
            cfg.interp = INTERP_W'(1);
        else if (interp_reg > INTERP_W'(MAX_INTERP))
            cfg.interp = INTERP_W'(MAX_INTERP);
        else
            cfg.interp = interp_reg;
        cfg.pad = (pad_reg > PAD_W'(MAX_ZERO_PAD)) ? PAD_W'(MAX_ZERO_PAD) : pad_reg;
        cfg.pre_syms = pre_syms_reg;
        cfg.pre_len = (pre_len_reg > LEN_W'(MAX_PREAMBLE)) ?
                      LEN_W'(MAX_PREAMBLE) : pre_len_reg;
        cfg.tail_syms = tail_syms_reg;
        cfg.tail_len = (tail_len_reg > LEN_W'(MAX_TAIL)) ?
                       LEN_W'(MAX_TAIL) : tail_len_reg;
    end

endmodule

>>> rtl/bfnr_seq.sv
// ----------------------------------------------------------------------------
// bfnr_seq
// Sample sequencer: walks pad, preamble, data, tail and pad sections with one
// repeat counter; preamble and tail share one symbol counter and byte shifter.
// ----------------------------------------------------------------------------
module bfnr_seq
    import bfnr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_fire,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    output logic              busy,
    output logic              emit_valid,
    output samp_t             emit,
    input  logic              emit_take
);

    phase_t                 phase_reg, phase_next;
    logic                   mid_burst_reg, mid_burst_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SYM_IDX_W-1:0]   sym_reg, sym_next;
    logic [SYMS_W-1:0]      shift_reg, shift_next;
    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic                   last_reg, last_next;
    logic                   first_reg, first_next;

    logic                   pad_nz, pre_nz, tail_nz;
    logic                   rep_done, zero_done, sym_last, phase_done;
    phase_t                 after_ph, start_ph;
    logic [BYTE_W-1:0]      cur_byte;
    logic [LEN_W-1:0]       cur_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            mid_burst_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mid_burst_reg <= mid_burst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        sym_reg   <= sym_next;
        shift_reg <= shift_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        first_reg <= first_next;
    end

    always_comb
    begin
        pad_nz  = (cfg.pad != '0);
        pre_nz  = (cfg.pre_len != '0);
        tail_nz = (cfg.tail_len != '0);

        cur_byte  = (phase_reg == PH_DATA) ? byte_reg : shift_reg[BYTE_W-1:0];
        cur_len   = (phase_reg == PH_TAIL) ? cfg.tail_len : cfg.pre_len;
        rep_done  = (cnt_reg == cfg.interp - INTERP_W'(1));
        zero_done = ({1'b0, cnt_reg} == cfg.pad - PAD_W'(1));
        sym_last  = ({1'b0, sym_reg} == cur_len - LEN_W'(1));

        case (phase_reg)
            PH_PRE_ZERO, PH_POST_ZERO: phase_done = zero_done;
            PH_PREAMBLE, PH_TAIL:      phase_done = rep_done && sym_last;
            PH_DATA:                   phase_done = rep_done;
            default:                   phase_done = 1'b0;
        endcase

        after_ph = phase_after(phase_reg, first_reg, last_reg, pad_nz, pre_nz, tail_nz);
        start_ph = phase_after(PH_IDLE, !mid_burst_reg, in_last, pad_nz, pre_nz, tail_nz);

        busy       = (phase_reg != PH_IDLE);
        emit_valid = busy;
        if (phase_reg == PH_PRE_ZERO || phase_reg == PH_POST_ZERO)
            emit.sample = '0;
        else
            emit.sample = map_symbol(cfg.nrz, cur_byte);
        emit.last_of_item  = phase_done && (after_ph == PH_IDLE);
        emit.last_of_burst = phase_done && (after_ph == PH_IDLE) && last_reg;

        phase_next     = phase_reg;
        mid_burst_next = mid_burst_reg;
        cnt_next       = cnt_reg;
        sym_next       = sym_reg;
        shift_next     = shift_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        first_next     = first_reg;

        if (!busy)
        begin
            if (in_fire)
            begin
                phase_next     = start_ph;
                mid_burst_next = 1'b1;
                cnt_next       = '0;
                sym_next       = '0;
                shift_next     = cfg.pre_syms;
                byte_next      = in_byte;
                last_next      = in_last;
                first_next     = !mid_burst_reg;
            end
        end
        else if (emit_take)
        begin
            if (phase_done)
            begin
                phase_next = after_ph;
                cnt_next   = '0;
                sym_next   = '0;
                // The shifter is reloaded for whichever symbol section comes next.
                shift_next = (after_ph == PH_TAIL) ? cfg.tail_syms : cfg.pre_syms;
                if (after_ph == PH_IDLE && last_reg)
                    mid_burst_next = 1'b0;
            end
            else if ((phase_reg == PH_PREAMBLE || phase_reg == PH_TAIL) && rep_done)
            begin
                cnt_next   = '0;
                sym_next   = sym_reg + SYM_IDX_W'(1);
                shift_next = shift_reg >> BYTE_W;
            end
            else if (phase_reg == PH_DATA && rep_done)
            begin
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    a_burst_implies_item: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid && emit.last_of_burst |-> emit.last_of_item)
        else $error("last_of_burst without last_of_item");

    a_item_end_idles: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid && emit_take && emit.last_of_item |=> phase_reg == PH_IDLE)
        else $error("sequencer still busy after the last sample of an item");

    a_burst_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid && emit_take && emit.last_of_burst |=> !mid_burst_reg)
        else $error("burst still open after its last sample");

endmodule

>>> rtl/bfnr_outreg.sv
// ----------------------------------------------------------------------------
// bfnr_outreg
// Output register: holds one sample until the downstream side takes it.
// ----------------------------------------------------------------------------
module bfnr_outreg
    import bfnr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  emit_valid,
    input  samp_t emit,
    output logic  emit_take,
    output logic  out_valid,
    input  logic  out_stall,
    output samp_t out_data
);

    logic  valid_reg, valid_next;
    samp_t data_reg, data_next;
    logic  load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        // The register may be refilled whenever it is empty or being drained.
        load       = !valid_reg || !out_stall;
        emit_take  = emit_valid && load;
        valid_next = load ? emit_valid : valid_reg;
        data_next  = emit_take ? emit : data_reg;
        out_valid  = valid_reg;
        out_data   = data_reg;
    end

endmodule
